>>> sv/cqpit_pkg.sv
`timescale 1ns / 1ps

package cqpit_pkg;

   // Default coordinate width; the top level may override it (4 to 30).
   localparam int COORD_WIDTH_DEF = 16;

   localparam int NUM_VERTS  = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   // Register map, one word per coordinate, byte address 4 * index.
   typedef enum logic [REG_IDX_W-1:0] {
      REG_V0_X = 3'd0,
      REG_V0_Y = 3'd1,
      REG_V1_X = 3'd2,
      REG_V1_Y = 3'd3,
      REG_V2_X = 3'd4,
      REG_V2_Y = 3'd5,
      REG_V3_X = 3'd6,
      REG_V3_Y = 3'd7
   } reg_idx_type;

   // Winding of the configured quad, derived from twice its signed area.
   typedef struct packed {
      logic nonzero;
      logic positive;
   } area_flags_type;

endpackage

>>> sv/cqpit_req_if.sv
`timescale 1ns / 1ps

interface cqpit_req_if import cqpit_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;

   modport source (output valid, output point_x, output point_y, input ready);
   modport sink (input valid, input point_x, input point_y, output ready);
endinterface

>>> sv/cqpit_rsp_if.sv
`timescale 1ns / 1ps

interface cqpit_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;
   logic in_bounding_box;

   modport source (output valid, output inside_res, output in_bounding_box, input ready);
   modport sink (input valid, input inside_res, input in_bounding_box, output ready);
endinterface

>>> sv/cqpit_csr.sv
`timescale 1ns / 1ps

module cqpit_csr import cqpit_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_W-1:0]         paddr,
   input  logic [CSR_DATA_W-1:0]         pwdata,
   output logic [CSR_DATA_W-1:0]         prdata,
   output logic signed [COORD_WIDTH-1:0] vert_x [NUM_VERTS],
   output logic signed [COORD_WIDTH-1:0] vert_y [NUM_VERTS],
   output logic signed [COORD_WIDTH-1:0] min_x,
   output logic signed [COORD_WIDTH-1:0] max_x,
   output logic signed [COORD_WIDTH-1:0] min_y,
   output logic signed [COORD_WIDTH-1:0] max_y,
   output area_flags_type                area_flags
);

   localparam int PW = 2 * COORD_WIDTH;
   localparam int AW = 2 * COORD_WIDTH + 3;

   logic signed [COORD_WIDTH-1:0] vx_ff [NUM_VERTS];
   logic signed [COORD_WIDTH-1:0] vy_ff [NUM_VERTS];
   logic signed [COORD_WIDTH-1:0] vx_in [NUM_VERTS];
   logic signed [COORD_WIDTH-1:0] vy_in [NUM_VERTS];
   logic signed [COORD_WIDTH-1:0] wdata;
   logic signed [COORD_WIDTH-1:0] rsel;
   reg_idx_type                   idx;
   logic                          wr_en;

   logic signed [COORD_WIDTH-1:0] mn_x01, mn_x23, mx_x01, mx_x23;
   logic signed [COORD_WIDTH-1:0] mn_y01, mn_y23, mx_y01, mx_y23;
   logic signed [COORD_WIDTH-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic signed [COORD_WIDTH-1:0] min_x_in, max_x_in, min_y_in, max_y_in;

   logic signed [PW-1:0] apl_ff [NUM_VERTS];
   logic signed [PW-1:0] apr_ff [NUM_VERTS];
   logic signed [PW-1:0] apl_in [NUM_VERTS];
   logic signed [PW-1:0] apr_in [NUM_VERTS];
   logic signed [AW-1:0] area2;

   assign idx   = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en = psel && penable && pwrite;
   assign wdata = pwdata[COORD_WIDTH-1:0];

   // Register writes land in the access phase.
   always_comb begin
      vx_in = vx_ff;
      vy_in = vy_ff;
      if (wr_en) begin
         unique case (idx)
            REG_V0_X: vx_in[0] = wdata;
            REG_V0_Y: vy_in[0] = wdata;
            REG_V1_X: vx_in[1] = wdata;
            REG_V1_Y: vy_in[1] = wdata;
            REG_V2_X: vx_in[2] = wdata;
            REG_V2_Y: vy_in[2] = wdata;
            REG_V3_X: vx_in[3] = wdata;
            REG_V3_Y: vy_in[3] = wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_V0_X: rsel = vx_ff[0];
         REG_V0_Y: rsel = vy_ff[0];
         REG_V1_X: rsel = vx_ff[1];
         REG_V1_Y: rsel = vy_ff[1];
         REG_V2_X: rsel = vx_ff[2];
         REG_V2_Y: rsel = vy_ff[2];
         REG_V3_X: rsel = vx_ff[3];
         REG_V3_Y: rsel = vy_ff[3];
         default:  rsel = '0;
      endcase
   end

   assign prdata = CSR_DATA_W'(rsel);

   // Bounding box of the corners, registered from the stored corners.
   always_comb begin
      mn_x01   = (vx_ff[0] < vx_ff[1]) ? vx_ff[0] : vx_ff[1];
      mn_x23   = (vx_ff[2] < vx_ff[3]) ? vx_ff[2] : vx_ff[3];
      mx_x01   = (vx_ff[0] > vx_ff[1]) ? vx_ff[0] : vx_ff[1];
      mx_x23   = (vx_ff[2] > vx_ff[3]) ? vx_ff[2] : vx_ff[3];
      mn_y01   = (vy_ff[0] < vy_ff[1]) ? vy_ff[0] : vy_ff[1];
      mn_y23   = (vy_ff[2] < vy_ff[3]) ? vy_ff[2] : vy_ff[3];
      mx_y01   = (vy_ff[0] > vy_ff[1]) ? vy_ff[0] : vy_ff[1];
      mx_y23   = (vy_ff[2] > vy_ff[3]) ? vy_ff[2] : vy_ff[3];
      min_x_in = (mn_x01 < mn_x23) ? mn_x01 : mn_x23;
      max_x_in = (mx_x01 > mx_x23) ? mx_x01 : mx_x23;
      min_y_in = (mn_y01 < mn_y23) ? mn_y01 : mn_y23;
      max_y_in = (mx_y01 > mx_y23) ? mx_y01 : mx_y23;
   end

   // Shoelace products, one register stage ahead of the sum.
   always_comb begin
      for (int i = 0; i < NUM_VERTS; i++) begin
         apl_in[i] = vx_ff[i] * vy_ff[(i + 1) % NUM_VERTS];
         apr_in[i] = vx_ff[(i + 1) % NUM_VERTS] * vy_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VERTS; i++) begin
            vx_ff[i]  <= '0;
            vy_ff[i]  <= '0;
            apl_ff[i] <= '0;
            apr_ff[i] <= '0;
         end
         min_x_ff <= '0;
         max_x_ff <= '0;
         min_y_ff <= '0;
         max_y_ff <= '0;
      end else begin
         vx_ff    <= vx_in;
         vy_ff    <= vy_in;
         apl_ff   <= apl_in;
         apr_ff   <= apr_in;
         min_x_ff <= min_x_in;
         max_x_ff <= max_x_in;
         min_y_ff <= min_y_in;
         max_y_ff <= max_y_in;
      end
   end

   assign area2 = (AW'(apl_ff[0]) - AW'(apr_ff[0])) + (AW'(apl_ff[1]) - AW'(apr_ff[1]))
                + (AW'(apl_ff[2]) - AW'(apr_ff[2])) + (AW'(apl_ff[3]) - AW'(apr_ff[3]));

   assign area_flags.nonzero  = (area2 != '0);
   assign area_flags.positive = !area2[AW-1] && (area2 != '0);

   assign vert_x = vx_ff;
   assign vert_y = vy_ff;
   assign min_x  = min_x_ff;
   assign max_x  = max_x_ff;
   assign min_y  = min_y_ff;
   assign max_y  = max_y_ff;

endmodule

>>> sv/cqpit_datapath.sv
`timescale 1ns / 1ps

module cqpit_datapath import cqpit_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] point_x,
   input  logic signed [COORD_WIDTH-1:0] point_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          inside_res,
   output logic                          in_bounding_box,
   input  logic signed [COORD_WIDTH-1:0] vert_x [NUM_VERTS],
   input  logic signed [COORD_WIDTH-1:0] vert_y [NUM_VERTS],
   input  logic signed [COORD_WIDTH-1:0] min_x,
   input  logic signed [COORD_WIDTH-1:0] max_x,
   input  logic signed [COORD_WIDTH-1:0] min_y,
   input  logic signed [COORD_WIDTH-1:0] max_y,
   input  area_flags_type                area_flags
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;
   localparam int EW = PW + 1;

   logic                          adv;
   logic                          v0_ff, v1_ff, v2_ff;
   logic signed [COORD_WIDTH-1:0] px_ff, py_ff;
   logic signed [DW-1:0]          dx [NUM_VERTS];
   logic signed [DW-1:0]          dy [NUM_VERTS];
   logic signed [PW-1:0]          pl_in [NUM_VERTS];
   logic signed [PW-1:0]          pr_in [NUM_VERTS];
   logic signed [PW-1:0]          pl_ff [NUM_VERTS];
   logic signed [PW-1:0]          pr_ff [NUM_VERTS];
   logic                          box_in, box_ff;
   logic signed [EW-1:0]          edge_val [NUM_VERTS];
   logic                          ok_in, inside_in;
   logic                          inside_ff, box2_ff;

   // Whole pipe moves together unless a finished result is held.
   assign adv       = !v2_ff || rsp_ready;
   assign req_ready = adv;

   always_comb begin
      for (int i = 0; i < NUM_VERTS; i++) begin
         dx[i] = DW'(vert_x[i]) - DW'(px_ff);
         dy[i] = DW'(vert_y[i]) - DW'(py_ff);
      end
      for (int i = 0; i < NUM_VERTS; i++) begin
         pl_in[i] = dx[i] * dy[(i + 1) % NUM_VERTS];
         pr_in[i] = dy[i] * dx[(i + 1) % NUM_VERTS];
      end
      box_in = (px_ff >= min_x) && (px_ff <= max_x) && (py_ff >= min_y) && (py_ff <= max_y);
   end

   // Every edge product must agree with the winding or be zero.
   always_comb begin
      ok_in = 1'b1;
      for (int i = 0; i < NUM_VERTS; i++) begin
         edge_val[i] = EW'(pl_ff[i]) - EW'(pr_ff[i]);
         if (area_flags.positive) begin
            if (edge_val[i][EW-1]) ok_in = 1'b0;
         end else begin
            if (!edge_val[i][EW-1] && (edge_val[i] != '0)) ok_in = 1'b0;
         end
      end
      inside_in = box_ff && area_flags.nonzero && ok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff     <= point_x;
         py_ff     <= point_y;
         pl_ff     <= pl_in;
         pr_ff     <= pr_in;
         box_ff    <= box_in;
         inside_ff <= inside_in;
         box2_ff   <= box_ff;
      end
   end

   assign rsp_valid       = v2_ff;
   assign inside_res      = inside_ff;
   assign in_bounding_box = box2_ff;

endmodule

>>> sv/convex_quad_point_inside_test.sv
`timescale 1ns / 1ps

// Point-in-convex-quadrilateral test.
// Program the four corners, in order around the quad, through the csr_ APB
// port (one signed coordinate per word, vertex0_x at byte 0 up to vertex3_y
// at byte 28). Write them only while no point is in flight.
// Each point sent on req_bus returns one transfer on rsp_bus carrying
// in_bounding_box (point within the inclusive corner box) and inside_res
// (point inside or on the quad; always 0 for a zero-area quad).
// A result passes the input register, the edge-product register and the
// result register before it shows as valid on rsp_bus.
// Throughput: one point per cycle while the receiver takes results, with a
// multiplier for every edge product, all working in parallel.
// Reset clears the corners to zero and empties the pipe; rsp_bus.valid drops.
// When the receiver stalls, the result register holds and the whole pipe
// freezes, so req_bus.ready falls in the same cycle; nothing is dropped.
// Corner-derived terms (box limits, area products) are registered from the
// stored corners after a write, ahead of any point that follows.
module convex_quad_point_inside_test import cqpit_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   cqpit_req_if.sink             req_bus,
   cqpit_rsp_if.source           rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic signed [COORD_WIDTH-1:0] vert_x [NUM_VERTS];
   logic signed [COORD_WIDTH-1:0] vert_y [NUM_VERTS];
   logic signed [COORD_WIDTH-1:0] min_x, max_x, min_y, max_y;
   area_flags_type                area_flags;

   // Register access never waits.
   assign csr_pready = 1'b1;

   cqpit_csr #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .vert_x     (vert_x),
      .vert_y     (vert_y),
      .min_x      (min_x),
      .max_x      (max_x),
      .min_y      (min_y),
      .max_y      (max_y),
      .area_flags (area_flags)
   );

   // Three-stage test pipe; the result register doubles as the output buffer.
   cqpit_datapath #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_bus.valid),
      .req_ready       (req_bus.ready),
      .point_x         (req_bus.point_x),
      .point_y         (req_bus.point_y),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .inside_res      (rsp_bus.inside_res),
      .in_bounding_box (rsp_bus.in_bounding_box),
      .vert_x          (vert_x),
      .vert_y          (vert_y),
      .min_x           (min_x),
      .max_x           (max_x),
      .min_y           (min_y),
      .max_y           (max_y),
      .area_flags      (area_flags)
   );

endmodule

>>> sv/cqpit_checker.sv
`timescale 1ns / 1ps

module cqpit_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic inside_res,
   input logic in_bounding_box
);

   // Pipe is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A held result keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(inside_res) && $stable(in_bounding_box))
      else $error("stalled result changed");

   // With the receiver ready, a request comes out as a valid result.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("result missing after request");

   // An empty output stage never blocks the input.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   // Inside implies inside the corner box.
   a_inside_box: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && inside_res |-> in_bounding_box)
      else $error("inside reported outside the box");

endmodule

bind convex_quad_point_inside_test cqpit_checker u_cqpit_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .inside_res      (rsp_bus.inside_res),
   .in_bounding_box (rsp_bus.in_bounding_box)
);

>>> dv/tb_convex_quad_point_inside_test.sv
`timescale 1ns / 1ps

module tb_convex_quad_point_inside_test import cqpit_pkg::*;;

   localparam int CW           = COORD_WIDTH_DEF;
   localparam int CLK_HALF     = 10;
   // Cycles to let pass after the last result; the pipe is three stages deep.
   localparam int DRAIN_CYCLES = 6;
   // Hard stop for the run; allow several times the slowest legal run.
   localparam int RUN_LIMIT_NS = 8_000_000;

   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
   } point_type;

   typedef struct {
      logic signed [CW-1:0] point_x;
      logic signed [CW-1:0] point_y;
      logic                 inside_res;
      logic                 in_bounding_box;
   } point_verdict_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cqpit_req_if #(.COORD_WIDTH(CW)) req_bus ();
   cqpit_rsp_if                     rsp_bus ();

   convex_quad_point_inside_test #(.COORD_WIDTH(CW)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus.sink),
      .rsp_bus     (rsp_bus.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow of the corner registers, in register-map order.
   logic signed [CW-1:0] corner_reg [8];

   point_type         point_q[$];    // points waiting to be sent
   point_verdict_type verdict_q[$];  // verdicts owed by the block, oldest first
   int                mismatches = 0;

   bit send_calm;
   bit drain_calm;
   int send_gap;
   int drain_stall;

   // ---------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------
   always #(CLK_HALF) clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor: bounding box plus one cross product per edge, signed by
   // twice the quad's area. A zero area never reports inside.
   // ---------------------------------------------------------------------
   function automatic point_verdict_type classify_point(logic signed [CW-1:0] px,
                                                        logic signed [CW-1:0] py);
      longint            vx[4];
      longint            vy[4];
      longint            lo_x, hi_x, lo_y, hi_y;
      longint            area2;
      longint            ecp;
      longint            x, y;
      int                j;
      bit                inbox, hit;
      point_verdict_type v;
      x = longint'(px);
      y = longint'(py);
      for (int i = 0; i < NUM_VERTS; i++) begin
         vx[i] = longint'(corner_reg[2*i]);
         vy[i] = longint'(corner_reg[2*i+1]);
      end
      lo_x = vx[0]; hi_x = vx[0];
      lo_y = vy[0]; hi_y = vy[0];
      for (int i = 1; i < NUM_VERTS; i++) begin
         if (vx[i] < lo_x) lo_x = vx[i];
         if (vx[i] > hi_x) hi_x = vx[i];
         if (vy[i] < lo_y) lo_y = vy[i];
         if (vy[i] > hi_y) hi_y = vy[i];
      end
      inbox = (x >= lo_x) && (x <= hi_x) && (y >= lo_y) && (y <= hi_y);
      area2 = 0;
      for (int i = 0; i < NUM_VERTS; i++) begin
         j = (i + 1) % NUM_VERTS;
         area2 += vx[i] * vy[j] - vx[j] * vy[i];
      end
      hit = inbox && (area2 != 0);
      for (int i = 0; i < NUM_VERTS; i++) begin
         j = (i + 1) % NUM_VERTS;
         ecp = (vx[i] - x) * (vy[j] - y) - (vy[i] - y) * (vx[j] - x);
         // Clockwise quads flip the sign that counts as inside.
         if (area2 > 0 ? (ecp < 0) : (ecp > 0)) hit = 1'b0;
      end
      v.point_x         = px;
      v.point_y         = py;
      v.inside_res      = hit;
      v.in_bounding_box = inbox;
      return v;
   endfunction

   // Mostly back-to-back, some short gaps, a few long ones.
   function automatic int draw_gap(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(24, 6);
   endfunction

   function automatic int pick(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic int clamp_coord(int v);
      if (v < -(1 << (CW - 1))) return -(1 << (CW - 1));
      if (v > (1 << (CW - 1)) - 1) return (1 << (CW - 1)) - 1;
      return v;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------
   // Request driver: hold the point until its transfer, then pop the next
   // one after a random gap. Each accepted point gets its verdict queued.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      bit        busy;
      point_type nxt;
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.point_x <= '0;
         req_bus.point_y <= '0;
         send_gap = 0;
      end else begin
         busy = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            verdict_q.push_back(classify_point(req_bus.point_x, req_bus.point_y));
            busy = 1'b0;
         end
         if ($urandom_range(63) == 0) send_calm = !send_calm;
         if (!busy) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (point_q.size() > 0) begin
               nxt = point_q.pop_front();
               req_bus.point_x <= nxt.x;
               req_bus.point_y <= nxt.y;
               req_bus.valid   <= 1'b1;
               send_gap = draw_gap(send_calm);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: check each transfer against the oldest verdict, and
   // drop ready at random to stall the pipe.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      point_verdict_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         drain_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (verdict_q.size() == 0) begin
               report_mismatch("result transfer with no point outstanding");
            end else begin
               want = verdict_q.pop_front();
               if (rsp_bus.in_bounding_box !== want.in_bounding_box)
                  report_mismatch($sformatf("point (%0d,%0d) in_bounding_box %b, want %b",
                     want.point_x, want.point_y, rsp_bus.in_bounding_box,
                     want.in_bounding_box));
               if (rsp_bus.inside_res !== want.inside_res)
                  report_mismatch($sformatf("point (%0d,%0d) inside_res %b, want %b",
                     want.point_x, want.point_y, rsp_bus.inside_res, want.inside_res));
            end
         end
         if ($urandom_range(63) == 0) drain_calm = !drain_calm;
         if (drain_stall > 0) begin
            drain_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            drain_stall = draw_gap(drain_calm);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Wait until every queued point has been sent and answered, then let the
   // pipe settle. Sample on the falling edge so driver updates have landed.
   task automatic wait_drained();
      @(negedge clock);
      while (point_q.size() > 0 || req_bus.valid || verdict_q.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One APB write: setup cycle, then access cycle until pready. The upper
   // half of the word is sometimes junk, which the block must ignore.
   task automatic write_corner(reg_idx_type idx, int value);
      logic [CSR_DATA_W-1:0] word;
      logic signed [CW-1:0]  coord;
      coord = CW'(value);
      word  = {{(CSR_DATA_W-CW){coord[CW-1]}}, coord};
      if ($urandom_range(1)) word[CSR_DATA_W-1:CW] = (CSR_DATA_W-CW)'($urandom());
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      corner_reg[idx] = coord;
   endtask

   task automatic program_quad(int x0, int y0, int x1, int y1,
                               int x2, int y2, int x3, int y3);
      wait_drained();
      write_corner(REG_V0_X, x0);
      write_corner(REG_V0_Y, y0);
      write_corner(REG_V1_X, x1);
      write_corner(REG_V1_Y, y1);
      write_corner(REG_V2_X, x2);
      write_corner(REG_V2_Y, y2);
      write_corner(REG_V3_X, x3);
      write_corner(REG_V3_Y, y3);
   endtask

   task automatic send_point(int x, int y);
      point_type p;
      p.x = CW'(x);
      p.y = CW'(y);
      point_q.push_back(p);
   endtask

   // Random quad, then a batch of points aimed mostly at its box and edges.
   task automatic run_random_phase(int count);
      int vx[4];
      int vy[4];
      int cx, cy, span, dx, dy, mode, r, k;
      int lo_x, hi_x, lo_y, hi_y;
      int px, py, tmp;
      mode = $urandom_range(9);
      cx   = pick(-30000, 30000);
      cy   = pick(-30000, 30000);
      span = (mode == 6) ? pick(1000, 32767) : pick(1, 60);
      if (mode == 6) begin
         cx = pick(-2000, 2000);
         cy = pick(-2000, 2000);
      end
      // Star-shaped: one corner per quadrant, counter-clockwise.
      vx[0] = cx + pick(0, span); vy[0] = cy - pick(0, span);
      vx[1] = cx + pick(0, span); vy[1] = cy + pick(0, span);
      vx[2] = cx - pick(0, span); vy[2] = cy + pick(0, span);
      vx[3] = cx - pick(0, span); vy[3] = cy - pick(0, span);
      if (mode == 7) begin
         // Arbitrary corners, any bit pattern; often self-crossing.
         for (int i = 0; i < NUM_VERTS; i++) begin
            vx[i] = pick(-32768, 32767);
            vy[i] = pick(-32768, 32767);
         end
      end else if (mode == 8) begin
         // Zero area: all corners on one line, possibly coincident.
         dx = pick(-8, 8);
         dy = pick(-8, 8);
         for (int i = 0; i < NUM_VERTS; i++) begin
            k = pick(-5, 5);
            vx[i] = cx + k * dx;
            vy[i] = cy + k * dy;
         end
      end else if (mode == 9) begin
         // Triangle: two corners share a spot.
         vx[3] = vx[0];
         vy[3] = vy[0];
      end
      for (int i = 0; i < NUM_VERTS; i++) begin
         vx[i] = clamp_coord(vx[i]);
         vy[i] = clamp_coord(vy[i]);
      end
      // Reverse the walk half the time to get a clockwise winding.
      if ($urandom_range(1)) begin
         tmp = vx[1]; vx[1] = vx[3]; vx[3] = tmp;
         tmp = vy[1]; vy[1] = vy[3]; vy[3] = tmp;
      end
      program_quad(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2], vx[3], vy[3]);
      lo_x = vx[0]; hi_x = vx[0];
      lo_y = vy[0]; hi_y = vy[0];
      for (int i = 1; i < NUM_VERTS; i++) begin
         if (vx[i] < lo_x) lo_x = vx[i];
         if (vx[i] > hi_x) hi_x = vx[i];
         if (vy[i] < lo_y) lo_y = vy[i];
         if (vy[i] > hi_y) hi_y = vy[i];
      end
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(9);
         px = clamp_coord(pick(lo_x - 2, hi_x + 2));
         py = clamp_coord(pick(lo_y - 2, hi_y + 2));
         if (r == 7) begin
            px = pick(-32768, 32767);
            py = pick(-32768, 32767);
         end else if (r == 8) begin
            // Land on or next to a corner.
            k  = $urandom_range(NUM_VERTS - 1);
            px = clamp_coord(vx[k] + pick(-1, 1));
            py = clamp_coord(vy[k] + pick(-1, 1));
         end else if (r == 9) begin
            py = pick(-32768, 32767);
         end
         send_point(px, py);
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      for (int i = 0; i < 8; i++) corner_reg[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // All corners at the origin after reset: zero area, box is one point.
      send_point(0, 0);
      send_point(1, 0);

      // Counter-clockwise square: center, corner, edge, just outside, extremes.
      program_quad(-100, -100, 100, -100, 100, 100, -100, 100);
      send_point(0, 0);
      send_point(100, 100);
      send_point(100, 0);
      send_point(101, 0);
      send_point(-100, -101);
      send_point(-32768, -32768);
      send_point(32767, 32767);

      // Same square walked clockwise.
      program_quad(-100, -100, -100, 100, 100, 100, 100, -100);
      send_point(0, 0);
      send_point(100, -100);
      send_point(0, 101);
      send_point(-50, 50);

      // Corners at the coordinate extremes; products reach their widest.
      program_quad(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767);
      send_point(-32768, -32768);
      send_point(32767, 32767);
      send_point(-32768, 32767);
      send_point(0, 0);

      // Collinear corners: box is reported, inside never is.
      program_quad(0, 0, 20, 20, 50, 50, 10, 10);
      send_point(0, 0);
      send_point(50, 50);
      send_point(10, 0);

      // Non-convex dart: the notch is in the box but fails an edge test.
      program_quad(0, 0, 100, 40, 0, 80, 30, 40);
      send_point(20, 40);
      send_point(60, 40);
      send_point(50, 10);

      // Random quads, random points.
      for (int ph = 0; ph < 12; ph++) run_random_phase(95);

      wait_drained();
      if (mismatches == 0) begin
         $display("PASS convex_quad_point_inside_test");
      end else begin
         $display("FAIL convex_quad_point_inside_test");
      end
      $finish;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #(RUN_LIMIT_NS);
      $display("FAIL convex_quad_point_inside_test");
      $finish;
   end

endmodule

>>> filelist.f
sv/cqpit_pkg.sv
sv/cqpit_req_if.sv
sv/cqpit_rsp_if.sv
sv/cqpit_csr.sv
sv/cqpit_datapath.sv
sv/convex_quad_point_inside_test.sv
sv/cqpit_checker.sv
dv/tb_convex_quad_point_inside_test.sv
